// ===== rtl/core/lgs_pkg.sv =====
// shared types and constants for the life grid generation step block
`default_nettype none

package lgs_pkg;

  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;

  // config register reset value (rows and columns in use)
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd50;

  // life rule neighbor counts
  localparam int LIVE_BIRTH = 3;
  localparam int LIVE_KEEP  = 2;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t              action;
    logic [COORD_W-1:0]   row_index;
    logic [COORD_W-1:0]   column_index;
    logic                 new_state;
  } lgs_in_t;

  typedef struct packed {
    logic cell_state;
    logic done_res;
  } lgs_out_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_WR_RD  = 3'd1,
    S_WR_WB  = 3'd2,
    S_RD_RD  = 3'd3,
    S_RD_OUT = 3'd4,
    S_ADV    = 3'd5,
    S_NOP    = 3'd6
  } lgs_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;     // capture the accepted item
    logic clear_buf;   // zero the row buffers
    logic rd_en;       // issue a grid row read
    logic rd_sel_adv;  // read address from the sweep, else from the item
    logic adv_shift;   // shift the row buffers
    logic adv_write;   // write a new generation row
    logic cell_write;  // write back the updated cell row
    logic emit;        // load the result register
    logic emit_done;   // done flag of the result
    logic emit_cell;   // result carries the read cell
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lgs_ctrl.sv =====
// controller state machine: sequences cell writes, reads, generation sweeps and no-op results
`default_nettype none

module lgs_ctrl import lgs_pkg::*; #(
  parameter int MAX_ROWS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire action_t                           action,
  input  wire logic [$clog2(MAX_ROWS+2)-1:0]     eff_rows,
  output logic                                   busy,
  output ctrl_cmd_t                              cmd,
  output logic [$clog2(MAX_ROWS)-1:0]            adv_rd_row,
  output logic [$clog2(MAX_ROWS)-1:0]            adv_wr_row
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int SW = $clog2(MAX_ROWS + 2);

  lgs_state_t    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          step_nxt    = '0;
          case (action)
            ACT_WRITE: begin
              state_nxt = S_WR_RD;
            end
            ACT_ADVANCE: begin
              cmd.clear_buf = 1'b1;
              state_nxt     = S_ADV;
            end
            ACT_READ: begin
              state_nxt = S_RD_RD;
            end
            default: begin
              state_nxt = S_NOP;
            end
          endcase
        end
      end
      S_WR_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR_WB;
      end
      S_WR_WB: begin
        cmd.cell_write = 1'b1;
        cmd.emit       = 1'b1;
        cmd.emit_done  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_RD_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_done = 1'b1;
        cmd.emit_cell = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ADV: begin
        // read row step, write back row step-2
        cmd.adv_shift = 1'b1;
        if (step_r < eff_rows) begin
          cmd.rd_en      = 1'b1;
          cmd.rd_sel_adv = 1'b1;
        end
        if (step_r >= SW'(2)) begin
          cmd.adv_write = 1'b1;
        end
        if (step_r == SW'(eff_rows + SW'(1))) begin
          cmd.emit      = 1'b1;
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          step_nxt = SW'(step_r + SW'(1));
        end
      end
      S_NOP: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign adv_rd_row = AW'(step_r);
  assign adv_wr_row = AW'(step_r - SW'(2));

  a_write_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv_write |-> step_r >= SW'(2))
    else $error("sweep wrote a row before the buffers were primed");

  a_emit_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == S_IDLE)
    else $error("controller not idle after a result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(cmd.adv_write || cmd.cell_write || cmd.rd_en))
    else $error("grid access while idle");

endmodule

`default_nettype wire

// ===== rtl/core/lgs_dp.sv =====
// datapath: config registers, grid memory, row buffers and life rule
`default_nettype none

module lgs_dp import lgs_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire cfg_reg_t                          cfg_index,
  input  wire logic [CFG_W-1:0]                  cfg_data,
  input  wire lgs_in_t                           in_item,
  input  wire ctrl_cmd_t                         cmd,
  input  wire logic [$clog2(MAX_ROWS)-1:0]       adv_rd_row,
  input  wire logic [$clog2(MAX_ROWS)-1:0]       adv_wr_row,
  output logic [$clog2(MAX_ROWS+2)-1:0]          eff_rows,
  output logic                                   out_valid,
  output lgs_out_t                               out_item
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int SW = $clog2(MAX_ROWS + 2);
  localparam int IW = (SW > CFG_W) ? SW : CFG_W;
  localparam int NC = MAX_COLUMNS;

  logic [CFG_W-1:0] rows_r, cols_r;
  lgs_in_t          item_r;

  logic [NC-1:0]    mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [NC-1:0]    q_row_r;
  logic             q_ok_r;
  logic [NC-1:0]    top_r, mid_r;

  logic [NC-1:0]    incoming, cmask, bitmask, cell_row, next_row, adv_row, wr_data;
  logic [AW-1:0]    cell_addr, rd_addr, wr_addr;
  logic             in_area, wr_en, cell_bit;
  lgs_out_t         out_item_r;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_RESET;
      cols_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_rows = (IW'(rows_r) > IW'(MAX_ROWS)) ? SW'(MAX_ROWS) : SW'(rows_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_item;
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      cmask[c] = (CFG_W'(c) < cols_r);
    end
  end

  assign in_area = (IW'(item_r.row_index) < IW'(eff_rows)) &&
                   (CFG_W'(item_r.column_index) < cols_r) &&
                   (CFG_W'(item_r.column_index) < CFG_W'(NC));

  assign cell_addr = AW'(item_r.row_index);
  assign rd_addr   = cmd.rd_sel_adv ? adv_rd_row : cell_addr;
  assign incoming  = q_ok_r ? q_row_r : '0;
  assign bitmask   = NC'(1) << item_r.column_index;
  assign cell_row  = item_r.new_state ? (incoming | bitmask) : (incoming & ~bitmask);
  assign cell_bit  = |(incoming & bitmask);

  // life rule over the three buffered rows, zero border at both ends
  always_comb begin
    logic [NC+1:0] pt, pm, pb;
    logic [3:0]    n;
    pt = {1'b0, top_r & cmask, 1'b0};
    pm = {1'b0, mid_r & cmask, 1'b0};
    pb = {1'b0, incoming & cmask, 1'b0};
    for (int c = 0; c < NC; c++) begin
      n = 4'(pt[c]) + 4'(pt[c+1]) + 4'(pt[c+2]) +
          4'(pm[c]) + 4'(pm[c+2]) +
          4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      next_row[c] = (n == 4'(LIVE_BIRTH)) || (pm[c+1] && (n == 4'(LIVE_KEEP)));
    end
  end

  // columns beyond the area in use keep their old bits
  assign adv_row = (next_row & cmask) | (mid_r & ~cmask);

  assign wr_en   = cmd.adv_write || (cmd.cell_write && in_area);
  assign wr_addr = cmd.adv_write ? adv_wr_row : cell_addr;
  assign wr_data = cmd.adv_write ? adv_row : cell_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      q_row_r <= mem[rd_addr];
    end
  end

  // a row never written since reset reads as all dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      q_ok_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      q_ok_r <= cmd.rd_en && row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_buf) begin
      top_r <= '0;
      mid_r <= '0;
    end else if (cmd.adv_shift) begin
      top_r <= mid_r;
      mid_r <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.cell_state <= cmd.emit_cell && in_area && cell_bit;
      out_item_r.done_res   <= cmd.emit_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_read_data_issued: assert property (@(posedge clk) disable iff (!rst_n)
    q_ok_r |-> $past(cmd.rd_en))
    else $error("row data marked valid without a read");

endmodule

`default_nettype wire

// ===== rtl/core/life_grid_generation_step.sv =====
// top level of the life grid generation step block
`default_nettype none

// Grid of one-bit cells under the B3/S23 life rule with a dead border and no
// wrap. Items enter on start while busy is low; each gives exactly one result
// on out_item, shown for one cycle with out_strobe, which the receiver cannot
// stall. A cell write is a row read, then a merged write back; a cell read is
// a row read, then the result; an unknown action just gives a result. In an
// advance the grid memory gives one full row per cycle, and a three-row
// window (two buffer rows plus the row just read) produces one new row per
// cycle while the older rows stay in the buffers as the snapshot.
// The result strobe comes in the cycle after the last busy cycle, in which a
// new item may already start. Reset clears the grid at once through one valid
// bit per row; no clearing sweep is needed. cfg_ready is always high; the user
// must write configuration only while the block is idle; it is not enforced.

module life_grid_generation_step import lgs_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // item channel
  input  wire logic             start,
  output logic                  busy,
  input  wire lgs_in_t          in_item,
  // result channel
  output logic                  out_strobe,
  output lgs_out_t              out_item,
  // config write channel
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire cfg_reg_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int SW = $clog2(MAX_ROWS + 2);

  ctrl_cmd_t     cmd;
  logic [SW-1:0] eff_rows;
  logic [AW-1:0] adv_rd_row, adv_wr_row;

  // config is always taken; a transfer completes on cfg_valid
  assign cfg_ready = 1'b1;

  // sequencer: one state per step of a write or read, one sweep state with a row counter for an advance
  lgs_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .action     (in_item.action),
    .eff_rows   (eff_rows),
    .busy       (busy),
    .cmd        (cmd),
    .adv_rd_row (adv_rd_row),
    .adv_wr_row (adv_wr_row)
  );

  // config registers, grid memory, row window, rule logic and result register
  lgs_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_item    (in_item),
    .cmd        (cmd),
    .adv_rd_row (adv_rd_row),
    .adv_wr_row (adv_wr_row),
    .eff_rows   (eff_rows),
    .out_valid  (out_strobe),
    .out_item   (out_item)
  );

  // a result always lands after its item has left the sequencer
  a_strobe_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while still busy");

endmodule

`default_nettype wire
